// ----- rtl/core/gdl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdl_pkg
// Shared types, constants and CRC helpers for the GDL90 frame deframer.
// ----------------------------------------------------------------------------
package gdl_pkg;

	localparam int STORE_DEPTH = 32;
	localparam int PAYLOAD_LEN = 27;
	localparam int BODY_LEN    = PAYLOAD_LEN + 2;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IDX_W       = 5;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_SEED  = 16'h0000;
	localparam logic [7:0]  ID_RESET  = 8'd20;

	localparam logic [1:0] FS_GOOD    = 2'd0;
	localparam logic [1:0] FS_BAD_CRC = 2'd1;
	localparam logic [1:0] FS_BAD_LEN = 2'd2;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_FLAG,
		PH_COLLECT
	} phase_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_PRIME,
		CS_CHECK,
		CS_DECIDE,
		CS_EMIT,
		CS_BAD_LEN,
		CS_BAD_CRC
	} ctl_state_t;

	typedef struct packed {
		logic       store_en;
		logic       store_xor;
		logic       fill_clr;
		logic       crc_init;
		logic       crc_en;
		logic       rd_clr;
		logic       rd_adv;
		logic       out_load;
		logic [1:0] out_status;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic is_flag;
		logic is_esc;
		logic is_id;
		logic fill_full;
		logic len_ok;
		logic crc_bad;
		logic body_end;
		logic pay_end;
		logic out_free;
	} dp_sts_t;

	// One table entry of the CRC-16 (poly 0x1021): shift the high byte through.
	function automatic logic [15:0] crc_tbl(input logic [7:0] hi);
		logic [15:0] v;
		v = {hi, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (v[15]) begin
				v = {v[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[14:0], 1'b0};
			end
		end
		return v;
	endfunction

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		return crc_tbl(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, b};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gdl_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdl_if
// Valid/ready channel interfaces: raw bytes, results and register writes.
// ----------------------------------------------------------------------------
interface gdl_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gdl_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [4:0] out_index;
	logic [1:0] frame_status;
	logic       last;

	modport source (output valid, output out_byte, output out_index, output frame_status,
		output last, input ready);
	modport sink   (input valid, input out_byte, input out_index, input frame_status,
		input last, output ready);
endinterface

interface gdl_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] accepted_msg_id;

	modport source (output valid, output accepted_msg_id, input ready);
	modport sink   (input valid, input accepted_msg_id, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gdl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdl_dp
// Deframer datapath: id register, frame store, fill count, CRC, result register.
// ----------------------------------------------------------------------------
module gdl_dp
	import gdl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [7:0]  cfg_data,
	input  wire logic [7:0]  rx_byte,
	input  wire dp_cmd_t     cmd,
	output dp_sts_t          sts,
	input  wire logic        res_ready,
	output logic             res_valid,
	output logic [7:0]       res_byte,
	output logic [IDX_W-1:0] res_index,
	output logic [1:0]       res_status,
	output logic             res_last
);

	logic [7:0]        id_q;
	logic [ADDR_W-1:0] fill_q;
	logic [ADDR_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [7:0]        rd_data_s1;
	logic [15:0]       crc_q;
	logic              bad_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [1:0]        out_status_q;
	logic              out_last_q;
	logic [7:0]        mem [STORE_DEPTH];
	logic [7:0]        wr_data;

	assign wr_data = cmd.store_xor ? (rx_byte ^ ESC_XOR) : rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= ID_RESET;
		end else if (cfg_valid) begin
			id_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_clr) begin
			fill_q <= '0;
		end else if (cmd.store_en) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// frame store: one write port at the fill count, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store_en) begin
			mem[fill_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_adv) begin
			rd_data_s1 <= mem[rd_q];
			rd_idx_s1  <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (cmd.rd_clr) begin
			rd_q <= '0;
		end else if (cmd.rd_adv) begin
			rd_q <= rd_q + 1'b1;
		end
	end

	// checksum over id and payload, then compare the stored lsb and msb
	always_ff @(posedge clk) begin
		if (cmd.crc_init) begin
			crc_q <= crc_update(CRC_SEED, id_q);
			bad_q <= 1'b0;
		end else if (cmd.crc_en) begin
			if (rd_idx_s1 < ADDR_W'(PAYLOAD_LEN)) begin
				crc_q <= crc_update(crc_q, rd_data_s1);
			end else if (rd_idx_s1 == ADDR_W'(PAYLOAD_LEN)) begin
				bad_q <= bad_q | (rd_data_s1 != crc_q[7:0]);
			end else begin
				bad_q <= bad_q | (rd_data_s1 != crc_q[15:8]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
			if (cmd.out_status == FS_GOOD) begin
				out_byte_q  <= rd_data_s1;
				out_index_q <= IDX_W'(rd_idx_s1);
			end else begin
				out_byte_q  <= '0;
				out_index_q <= '0;
			end
		end
	end

	assign sts.is_flag   = (rx_byte == FLAG_BYTE);
	assign sts.is_esc    = (rx_byte == ESC_BYTE);
	assign sts.is_id     = (rx_byte == id_q);
	assign sts.fill_full = (fill_q >= ADDR_W'(STORE_DEPTH - 1));
	assign sts.len_ok    = (fill_q == ADDR_W'(BODY_LEN));
	assign sts.crc_bad   = bad_q;
	assign sts.body_end  = (rd_idx_s1 == ADDR_W'(BODY_LEN - 1));
	assign sts.pay_end   = (rd_idx_s1 == ADDR_W'(PAYLOAD_LEN - 1));
	assign sts.out_free  = !out_valid_q || res_ready;

	assign res_valid  = out_valid_q;
	assign res_byte   = out_byte_q;
	assign res_index  = out_index_q;
	assign res_status = out_status_q;
	assign res_last   = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/core/gdl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdl_ctrl
// Deframer controller: link phase, escape tracking and the frame-end sequencer.
// ----------------------------------------------------------------------------
module gdl_ctrl
	import gdl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    rx_valid,
	output logic         rx_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	ctl_state_t state_q, state_d;
	phase_t     phase_q, phase_d;
	logic       esc_q, esc_d;
	logic       take;

	assign take = rx_valid && (state_q == CS_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			phase_q <= PH_WAIT;
			esc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			esc_q   <= esc_d;
		end
	end

	// next state: link phase and sequencer
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		esc_d   = esc_q;
		case (state_q)
			CS_IDLE: begin
				if (take) begin
					case (phase_q)
						PH_WAIT: begin
							if (sts.is_flag) phase_d = PH_FLAG;
						end
						PH_FLAG: begin
							if (sts.is_id) begin
								phase_d = PH_COLLECT;
								esc_d   = 1'b0;
							end else if (!sts.is_flag) begin
								phase_d = PH_WAIT;
							end
						end
						PH_COLLECT: begin
							if (esc_q || (!sts.is_esc && !sts.is_flag)) begin
								esc_d = 1'b0;
								if (sts.fill_full) phase_d = PH_WAIT;
							end else if (sts.is_esc) begin
								esc_d = 1'b1;
							end else begin
								phase_d = PH_WAIT;
								state_d = sts.len_ok ? CS_PRIME : CS_BAD_LEN;
							end
						end
						default: begin
							phase_d = PH_WAIT;
							esc_d   = 1'b0;
						end
					endcase
				end
			end
			CS_PRIME:   state_d = CS_CHECK;
			CS_CHECK: begin
				if (sts.body_end) state_d = CS_DECIDE;
			end
			CS_DECIDE:  state_d = sts.crc_bad ? CS_BAD_CRC : CS_EMIT;
			CS_EMIT: begin
				if (sts.out_free && sts.pay_end) state_d = CS_IDLE;
			end
			CS_BAD_LEN, CS_BAD_CRC: begin
				if (sts.out_free) state_d = CS_IDLE;
			end
			default:    state_d = CS_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd      = '0;
		rx_ready = (state_q == CS_IDLE);
		case (state_q)
			CS_IDLE: begin
				if (take) begin
					case (phase_q)
						PH_WAIT: begin
						end
						PH_FLAG: begin
							if (sts.is_id) cmd.fill_clr = 1'b1;
						end
						PH_COLLECT: begin
							if (esc_q || (!sts.is_esc && !sts.is_flag)) begin
								cmd.store_xor = esc_q;
								if (sts.fill_full) cmd.fill_clr = 1'b1;
								else               cmd.store_en = 1'b1;
							end else if (!sts.is_esc) begin
								cmd.fill_clr = 1'b1;
								cmd.crc_init = sts.len_ok;
								cmd.rd_clr   = sts.len_ok;
							end
						end
						default: cmd.fill_clr = 1'b1;
					endcase
				end
			end
			CS_PRIME: cmd.rd_adv = 1'b1;
			CS_CHECK: begin
				cmd.crc_en = 1'b1;
				if (sts.body_end) cmd.rd_clr = 1'b1;
				else              cmd.rd_adv = 1'b1;
			end
			CS_DECIDE: cmd.rd_adv = !sts.crc_bad;
			CS_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = FS_GOOD;
					cmd.out_last   = sts.pay_end;
					cmd.rd_adv     = !sts.pay_end;
				end
			end
			CS_BAD_LEN: begin
				cmd.out_load   = sts.out_free;
				cmd.out_status = FS_BAD_LEN;
				cmd.out_last   = 1'b1;
			end
			CS_BAD_CRC: begin
				cmd.out_load   = sts.out_free;
				cmd.out_status = FS_BAD_CRC;
				cmd.out_last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/gdl90_frame_deframer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gdl90_frame_deframer_top
// GDL90 link deframer: flag sync, id match, escape removal, CRC-16 check.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transaction when
//  cfg      in   accepted_msg_id[7:0]                      cfg.valid & cfg.ready
//  rx       in   rx_byte[7:0]                              rx.valid & rx.ready
//  res      out  out_byte, out_index, frame_status, last   res.valid & res.ready
//
//  Ordinary link bytes never stall; rx.ready stays high between frames.
//  A closing flag starts the frame-end sequencer, which walks the frame store
//  through its single registered read port: a prime step, a check pass over
//  the 29 stored bytes and a decide step make the CRC pass, then one payload
//  byte per cycle (27 bytes) while res is not stalled. A length failure, found
//  at the closing flag, or a checksum failure after the CRC pass, holds rx
//  until the result register is free and gives one status transaction.
//  arst_n clears the phase, escape flag, fill count, sequencer and the id
//  register (to 20); the frame store holds no reset. A stalled res holds the
//  result register and freezes the sequencer; cfg is always ready.
// ----------------------------------------------------------------------------
module gdl90_frame_deframer_top
	import gdl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	gdl_cfg_if.sink   cfg,
	gdl_rx_if.sink    rx,
	gdl_res_if.source res
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// register writes go straight into the id register, so never back-pressure them
	assign cfg.ready = 1'b1;

	// controller: owns rx.ready and all sequencing
	gdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: store, checksum and the result register feeding res
	gdl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg.valid),
		.cfg_data   (cfg.accepted_msg_id),
		.rx_byte    (rx.rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.res_ready  (res.ready),
		.res_valid  (res.valid),
		.res_byte   (res.out_byte),
		.res_index  (res.out_index),
		.res_status (res.frame_status),
		.res_last   (res.last)
	);

endmodule
`default_nettype wire
